@@ rtl/core/postfix_expression_evaluator_macros.svh @@
// ----------------------------------------------------------------------------
// Postfix evaluator assertion macros
// Immediate-implication and next-cycle-implication checks, removable as a set.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PEE_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("postfix evaluator check failed");
`define PEE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("postfix evaluator check failed");
`else
`define PEE_ASSERT_NOW(label, clk, rst, pre, post)
`define PEE_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

@@ rtl/core/pee_pkg.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Token and status codes, saturation limits and the microcode program.
// ----------------------------------------------------------------------------
package pee_pkg;

   localparam int VALUE_W = 32;
   localparam int MODE_W  = 3;
   localparam int TOL_W   = 31;

   typedef logic signed [VALUE_W-1:0] value_type;

   localparam value_type SAT_MAX = 32'sh7FFF_FFFF;
   localparam value_type SAT_MIN = 32'sh8000_0000;

   typedef enum logic [MODE_W-1:0] {
      MD_PUSH    = 3'd0,
      MD_ADD     = 3'd1,
      MD_SUB     = 3'd2,
      MD_MUL     = 3'd3,
      MD_DIV     = 3'd4,
      MD_INVALID = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_OVERFLOW = 3'd1,
      ST_UNDERFLOW = 3'd2,
      ST_DIVZERO  = 3'd3,
      ST_INVALID  = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      U_IDLE   = 4'd0,
      U_DECODE = 4'd1,
      U_PUSH   = 4'd2,
      U_RDB    = 4'd3,
      U_RDA    = 4'd4,
      U_LATA   = 4'd5,
      U_ADD    = 4'd6,
      U_MUL    = 4'd7,
      U_MULSH  = 4'd8,
      U_DCHK   = 4'd9,
      U_DWAIT  = 4'd10,
      U_WRITE  = 4'd11,
      U_END    = 4'd12,
      U_ANS    = 4'd13
   } uaddr_type;

   typedef enum logic [1:0] {RD_NONE, RD_TOP, RD_SEC} rd_type;
   typedef enum logic [1:0] {LAT_NONE, LAT_A, LAT_B} lat_type;
   typedef enum logic [2:0] {
      EXE_NONE, EXE_ADDSUB, EXE_MUL, EXE_MULSH, EXE_DIVCHK, EXE_DIVGET
   } exe_type;
   typedef enum logic [1:0] {WR_NONE, WR_PUSH, WR_RESULT} wr_type;
   typedef enum logic {FIN_NONE, FIN_ANSWER} fin_type;
   typedef enum logic [3:0] {
      NX_SEQ, NX_JMP, NX_ACCEPT, NX_DISPATCH, NX_OPSEL,
      NX_DIVCHK, NX_WAITDIV, NX_LAST, NX_WAITOUT
   } nxt_type;

   typedef struct packed {
      rd_type    rd;
      lat_type   lat;
      exe_type   exe;
      wr_type    wr;
      fin_type   fin;
      nxt_type   nxt;
      uaddr_type target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input uaddr_type addr);
      ucode_type w;
      w = '{rd: RD_NONE, lat: LAT_NONE, exe: EXE_NONE, wr: WR_NONE,
            fin: FIN_NONE, nxt: NX_JMP, target: U_IDLE};
      unique case (addr)
         U_IDLE: begin
            w.nxt = NX_ACCEPT;
            w.target = U_DECODE;
         end
         U_DECODE: begin
            w.nxt = NX_DISPATCH;
         end
         U_PUSH: begin
            w.wr = WR_PUSH;
            w.target = U_END;
         end
         U_RDB: begin
            w.rd = RD_TOP;
            w.nxt = NX_SEQ;
         end
         U_RDA: begin
            w.rd = RD_SEC;
            w.lat = LAT_B;
            w.nxt = NX_SEQ;
         end
         U_LATA: begin
            w.lat = LAT_A;
            w.nxt = NX_OPSEL;
         end
         U_ADD: begin
            w.exe = EXE_ADDSUB;
            w.target = U_WRITE;
         end
         U_MUL: begin
            w.exe = EXE_MUL;
            w.nxt = NX_SEQ;
         end
         U_MULSH: begin
            w.exe = EXE_MULSH;
            w.target = U_WRITE;
         end
         U_DCHK: begin
            w.exe = EXE_DIVCHK;
            w.nxt = NX_DIVCHK;
            w.target = U_END;
         end
         U_DWAIT: begin
            w.exe = EXE_DIVGET;
            w.nxt = NX_WAITDIV;
            w.target = U_WRITE;
         end
         U_WRITE: begin
            w.wr = WR_RESULT;
            w.target = U_END;
         end
         U_END: begin
            w.rd = RD_TOP;
            w.nxt = NX_LAST;
            w.target = U_ANS;
         end
         U_ANS: begin
            w.fin = FIN_ANSWER;
            w.nxt = NX_WAITOUT;
            w.target = U_IDLE;
         end
         default: begin
            w.target = U_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/pee_req_if.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator token channel
// One token per transaction: kind, pushed value and end-of-expression flag.
// ----------------------------------------------------------------------------
interface pee_req_if import pee_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   value_type         operand_value;
   logic              last_token;

   modport source (output valid, mode, operand_value, last_token, input ready);
   modport sink (input valid, mode, operand_value, last_token, output ready);
endinterface

@@ rtl/core/pee_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator result channel
// One answer with its status per completed expression.
// ----------------------------------------------------------------------------
interface pee_rsp_if import pee_pkg::*; ();
   logic       valid;
   logic       ready;
   value_type  answer;
   status_type status;

   modport source (output valid, answer, status, input ready);
   modport sink (input valid, answer, status, output ready);
endinterface

@@ rtl/core/pee_csr_if.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator configuration channel
// Write-only transaction carrying the divide-by-zero tolerance.
// ----------------------------------------------------------------------------
interface pee_csr_if import pee_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [TOL_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/pee_stack.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator operand stack memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module pee_stack import pee_pkg::*; #(
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  value_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output value_type     rd_data
);

   value_type stack_mem_ff [DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pee_div.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator fixed-point divider
// Restoring divider, one quotient bit per cycle, truncating and saturating.
// ----------------------------------------------------------------------------
module pee_div import pee_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  value_type dividend,
   input  value_type divisor,
   output logic      done,
   output value_type quotient
);

   localparam int DW = VALUE_W + FRACTION_BITS;
   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic               neg_ff;
   logic [VALUE_W-1:0] rem_ff;
   logic [VALUE_W-1:0] dmag_ff;
   logic [DW-1:0]      quo_ff;
   logic [VALUE_W-1:0] mag_a, mag_b;
   logic [VALUE_W:0]   trial;
   logic [VALUE_W:0]   diff;
   logic               qbit;
   logic               hi;
   logic [VALUE_W-1:0] quo_neg;

   assign mag_a = dividend[VALUE_W-1] ? (~dividend + 1'b1) : dividend;
   assign mag_b = divisor[VALUE_W-1] ? (~divisor + 1'b1) : divisor;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dmag_ff};
   assign qbit  = (trial >= {1'b0, dmag_ff});

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (start) begin
         cnt_in  = CW'(DW);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= dividend[VALUE_W-1] ^ divisor[VALUE_W-1];
         rem_ff  <= '0;
         dmag_ff <= mag_b;
         quo_ff  <= DW'(mag_a) << FRACTION_BITS;
      end else if (cnt_ff != '0) begin
         rem_ff <= qbit ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
         quo_ff <= {quo_ff[DW-2:0], qbit};
      end
   end

   assign hi      = |quo_ff[DW-1:VALUE_W-1];
   assign quo_neg = ~quo_ff[VALUE_W-1:0] + 1'b1;

   always_comb begin
      if (neg_ff) begin
         quotient = hi ? SAT_MIN : value_type'(quo_neg);
      end else begin
         quotient = hi ? SAT_MAX : value_type'(quo_ff[VALUE_W-1:0]);
      end
   end

   assign done = done_ff;

endmodule

@@ rtl/core/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Push: accept, decode, write. Add, subtract, multiply: read both operands,
// compute (multiply also shifts), write back; divide waits on the divider.
// A last token adds an answer step, registered onto the result channel once
// it is free. One token at a time. Synchronous reset empties the stack,
// clears the error and the tolerance; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator import pee_pkg::*; #(
   parameter int STACK_DEPTH   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   pee_req_if.sink    req_bus,
   pee_rsp_if.source  rsp_bus,
   pee_csr_if.sink    csr_bus
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   uaddr_type          upc_ff, upc_in;
   ucode_type          uw;
   logic [SPW-1:0]     sp_ff, sp_in, sp_m1, sp_m2;
   status_type         err_ff, err_in;
   logic [TOL_W-1:0]   tol_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   value_type          rsp_answer_ff;
   status_type         rsp_status_ff;

   logic [MODE_W-1:0]  tok_mode_ff;
   value_type          tok_value_ff;
   logic               tok_last_ff;
   value_type          a_ff, b_ff, r_ff;
   logic signed [63:0] prod_ff;

   logic               req_acc, out_free, ans_load, div_zero;
   uaddr_type          disp_target, opsel_target;
   status_type         disp_err;
   logic [VALUE_W:0]   addsub_full;
   value_type          addsub_sat, mulsh_sat;
   logic signed [63:0] prod_sh;
   logic [VALUE_W-1:0] b_mag;
   value_type          ans_value;
   status_type         ans_status;

   logic               st_wr_en, st_rd_en;
   logic [AW-1:0]      st_wr_addr, st_rd_addr;
   value_type          st_wr_data, st_rd_data;
   logic               div_start, div_done;
   value_type          div_q;

   assign uw       = ucode_rom(upc_ff);
   assign sp_m1    = sp_ff - SPW'(1);
   assign sp_m2    = sp_ff - SPW'(2);
   assign req_acc  = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign ans_load = (uw.fin == FIN_ANSWER) && out_free;

   assign req_bus.ready = !reset && (upc_ff == U_IDLE);
   assign csr_bus.ready = !reset;

   // token decode
   always_comb begin
      disp_target = U_END;
      disp_err    = ST_OK;
      if (err_ff == ST_OK) begin
         unique case (tok_mode_ff)
            MD_PUSH: begin
               if (sp_ff >= SPW'(STACK_DEPTH)) begin
                  disp_err = ST_OVERFLOW;
               end else begin
                  disp_target = U_PUSH;
               end
            end
            MD_ADD, MD_SUB, MD_MUL, MD_DIV: begin
               if (sp_ff < SPW'(2)) begin
                  disp_err = ST_UNDERFLOW;
               end else begin
                  disp_target = U_RDB;
               end
            end
            default: begin
               disp_err = ST_INVALID;
            end
         endcase
      end
   end

   always_comb begin
      unique case (tok_mode_ff)
         MD_ADD, MD_SUB: opsel_target = U_ADD;
         MD_MUL:         opsel_target = U_MUL;
         default:        opsel_target = U_DCHK;
      endcase
   end

   // arithmetic
   always_comb begin
      if (tok_mode_ff == MD_SUB) begin
         addsub_full = {a_ff[VALUE_W-1], a_ff} - {b_ff[VALUE_W-1], b_ff};
      end else begin
         addsub_full = {a_ff[VALUE_W-1], a_ff} + {b_ff[VALUE_W-1], b_ff};
      end
      if (addsub_full[VALUE_W] != addsub_full[VALUE_W-1]) begin
         addsub_sat = addsub_full[VALUE_W] ? SAT_MIN : SAT_MAX;
      end else begin
         addsub_sat = value_type'(addsub_full[VALUE_W-1:0]);
      end
   end

   assign prod_sh = prod_ff >>> FRACTION_BITS;

   always_comb begin
      if ((prod_sh[63:VALUE_W-1] == '0) || (prod_sh[63:VALUE_W-1] == '1)) begin
         mulsh_sat = value_type'(prod_sh[VALUE_W-1:0]);
      end else begin
         mulsh_sat = prod_sh[63] ? SAT_MIN : SAT_MAX;
      end
   end

   assign b_mag     = b_ff[VALUE_W-1] ? (~b_ff + 1'b1) : b_ff;
   assign div_zero  = (b_mag <= {1'b0, tol_ff});
   assign div_start = (uw.exe == EXE_DIVCHK) && !div_zero;

   always_comb begin
      if (err_ff != ST_OK) begin
         ans_value  = '0;
         ans_status = err_ff;
      end else if (sp_ff == '0) begin
         ans_value  = '0;
         ans_status = ST_EMPTY;
      end else begin
         ans_value  = st_rd_data;
         ans_status = ST_OK;
      end
   end

   // sequencer
   always_comb begin
      unique case (uw.nxt)
         NX_SEQ:      upc_in = uaddr_type'(upc_ff + 4'd1);
         NX_JMP:      upc_in = uw.target;
         NX_ACCEPT:   upc_in = req_acc ? uw.target : upc_ff;
         NX_DISPATCH: upc_in = disp_target;
         NX_OPSEL:    upc_in = opsel_target;
         NX_DIVCHK:   upc_in = div_zero ? uw.target : uaddr_type'(upc_ff + 4'd1);
         NX_WAITDIV:  upc_in = div_done ? uw.target : upc_ff;
         NX_LAST:     upc_in = tok_last_ff ? uw.target : U_IDLE;
         NX_WAITOUT:  upc_in = out_free ? uw.target : upc_ff;
         default:     upc_in = U_IDLE;
      endcase
   end

   always_comb begin
      sp_in  = sp_ff;
      err_in = err_ff;
      if (uw.nxt == NX_DISPATCH && disp_err != ST_OK) begin
         err_in = disp_err;
      end
      if (uw.exe == EXE_DIVCHK && div_zero) begin
         err_in = ST_DIVZERO;
         sp_in  = sp_m2;
      end
      if (uw.wr == WR_PUSH) begin
         sp_in = sp_ff + SPW'(1);
      end else if (uw.wr == WR_RESULT) begin
         sp_in = sp_m1;
      end
      if (ans_load) begin
         sp_in  = '0;
         err_in = ST_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ans_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= U_IDLE;
         sp_ff        <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= '0;
      end else begin
         upc_ff       <= upc_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            tol_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         tok_mode_ff  <= req_bus.mode;
         tok_value_ff <= req_bus.operand_value;
         tok_last_ff  <= req_bus.last_token;
      end
      if (uw.lat == LAT_B) begin
         b_ff <= st_rd_data;
      end
      if (uw.lat == LAT_A) begin
         a_ff <= st_rd_data;
      end
      unique case (uw.exe)
         EXE_ADDSUB: r_ff <= addsub_sat;
         EXE_MUL:    prod_ff <= a_ff * b_ff;
         EXE_MULSH:  r_ff <= mulsh_sat;
         EXE_DIVGET: begin
            if (div_done) begin
               r_ff <= div_q;
            end
         end
         default: ;
      endcase
      if (ans_load) begin
         rsp_answer_ff <= ans_value;
         rsp_status_ff <= ans_status;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.answer = rsp_answer_ff;
   assign rsp_bus.status = rsp_status_ff;

   // stack ports
   assign st_wr_en   = (uw.wr != WR_NONE);
   assign st_wr_addr = (uw.wr == WR_PUSH) ? sp_ff[AW-1:0] : sp_m2[AW-1:0];
   assign st_wr_data = (uw.wr == WR_PUSH) ? tok_value_ff : r_ff;
   assign st_rd_en   = (uw.rd != RD_NONE) && (sp_ff != '0);
   assign st_rd_addr = (uw.rd == RD_SEC) ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

   pee_stack #(
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   pee_div #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   `PEE_ASSERT_NOW(a_sp_range, clock, reset, 1'b1, sp_ff <= SPW'(STACK_DEPTH))
   `PEE_ASSERT_NEXT(a_acc_decode, clock, reset, req_acc, upc_ff == U_DECODE)
   `PEE_ASSERT_NEXT(a_ans_clear, clock, reset, ans_load, (sp_ff == '0) && (err_ff == ST_OK))
   `PEE_ASSERT_NEXT(a_err_hold, clock, reset, (err_ff != ST_OK) && !ans_load, err_ff == $past(err_ff))

endmodule
